// ----- src/nroot_pkg.sv -----
// ----------------------------------------------------------------------------
// nroot_pkg
// Shared constants and codes for the Newton n-th root unit.
// ----------------------------------------------------------------------------
package nroot_pkg;

   // default word format, signed fixed point
   localparam int DATA_BITS_DEF  = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field widths
   localparam int ORDER_BITS     = 6;
   localparam int TOL_BITS       = 32;
   localparam int STEP_BITS      = 12;
   localparam int CSR_INDEX_BITS = 4;

   // multiplier digit taken per cycle
   localparam int MUL_DIGIT      = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOLERANCE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_STEPS = 4'd1;

   // register reset values
   localparam logic [TOL_BITS-1:0]  TOL_RESET   = 32'd66;
   localparam logic [STEP_BITS-1:0] STEPS_RESET = 12'd64;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_ORDER = 2'd1,
      STATUS_NEG_EVEN  = 2'd2,
      STATUS_NO_CONV   = 2'd3
   } status_type;

endpackage

// ----- src/newton_nth_root_unit.sv -----
// ----------------------------------------------------------------------------
// newton_nth_root_unit
// Newton iteration for the n-th root of a signed fixed-point radicand.
// ----------------------------------------------------------------------------
// One request is worked at a time; req_ready is low from acceptance until the
// result is loaded into the response register. Order below 2, an even root of
// a negative value and a zero radicand skip the arithmetic. Otherwise the
// start estimate takes one divide, and every Newton round takes the power
// chain of n-1 multiplies, each taken 16 bits of the multiplier at a time,
// plus three divides. The final error check adds the power chain and one
// divide. All power-chain products go through one DATA_BITS x 16 multiplier
// and all quotients through one bit-serial divider, so these two units set
// the rate.
module newton_nth_root_unit #(
   parameter int DATA_BITS = nroot_pkg::DATA_BITS_DEF,
   parameter int FRAC_BITS = nroot_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [DATA_BITS-1:0]           req_radicand,
   input  logic [nroot_pkg::ORDER_BITS-1:0]      req_order,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [DATA_BITS-1:0]           rsp_root,
   output logic [DATA_BITS-1:0]                  rsp_rel_error,
   output logic [1:0]                            rsp_status,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [nroot_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [nroot_pkg::TOL_BITS-1:0]        csr_data
);
   import nroot_pkg::*;

   localparam int W    = DATA_BITS;
   localparam int NW   = W + 1 + FRAC_BITS;
   localparam int NDIG = (W + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int BPW  = NDIG * MUL_DIGIT;
   localparam int PW   = BPW + W;
   localparam int CW   = (W > TOL_BITS) ? W : TOL_BITS;
   localparam int MCW  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam logic [W-1:0] LIM    = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXMAG = {1'b0, {(W-1){1'b1}}};

   typedef enum logic [2:0] {
      S_IDLE, S_INIT, S_POW, S_ERRS, S_ERR, S_UPD1, S_UPD2, S_DONE
   } state_type;

   // clamp a magnitude to the signed range of its sign
   function automatic logic [W-1:0] sat_mag(input logic neg, input logic [W:0] m);
      logic [W:0] lim;
      lim = neg ? {1'b0, LIM} : {1'b0, MAXMAG};
      return (m > lim) ? lim[W-1:0] : m[W-1:0];
   endfunction

   state_type             state_ff;
   logic [TOL_BITS-1:0]   tol_ff;
   logic [STEP_BITS-1:0]  steps_max_ff;
   logic [STEP_BITS-1:0]  steps_ff;
   logic                  s_neg_ff;
   logic [W-1:0]          s_mag_ff;
   logic [ORDER_BITS-1:0] n_ff;
   logic                  r_neg_ff;
   logic [W-1:0]          r_mag_ff;
   logic                  p_neg_ff;
   logic [W-1:0]          p_mag_ff;
   logic                  pm1_neg_ff;
   logic [W-1:0]          pm1_mag_ff;
   logic                  t1_neg_ff;
   logic [W-1:0]          t1_mag_ff;
   logic [ORDER_BITS-1:0] k_ff;
   logic [PW-1:0]         acc_ff;
   logic [BPW-1:0]        b_ff;
   logic [MCW-1:0]        mcnt_ff;
   logic [W-1:0]          err_ff;
   status_type            status_ff;
   logic                  div_start_ff;
   logic [NW-1:0]         div_num_ff;
   logic [W-1:0]          div_den_ff;
   logic                  rsp_valid_ff;
   logic [W-1:0]          rsp_root_ff;
   logic [W-1:0]          rsp_err_ff;
   status_type            rsp_status_ff;

   logic                  div_done;
   logic [NW-1:0]         div_quot;

   logic [W+MUL_DIGIT-1:0] pprod_in;
   logic [PW-1:0]         acc_in;
   logic [PW-1:0]         mul_sh_in;
   logic [W:0]            mul_m_in;
   logic                  pn_neg_in;
   logic [W-1:0]          pn_mag_in;
   logic                  pn_negf_in;
   logic [W:0]            d_in;
   logic [W:0]            qm_in;
   logic [W-1:0]          err_sat_in;
   logic [W+ORDER_BITS-1:0] dprod_in;
   logic [W-1:0]          den_upd_in;
   logic [W-1:0]          t1m_in;
   logic                  t2_neg_in;
   logic [W-1:0]          t2_mag_in;
   logic                  rn_neg_in;
   logic [W-1:0]          rn_mag_in;
   logic                  a_neg_in;
   logic [W-1:0]          a_mag_in;
   logic                  in_neg_in;
   logic [W-1:0]          in_mag_in;
   logic                  req_take;

   nroot_div #(
      .NUM_BITS (NW),
      .DEN_BITS (W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign req_take = req_valid && req_ready;

   always_comb begin
      // multiply-accumulate one digit of r, top digit first
      pprod_in  = p_mag_ff * b_ff[BPW-1 -: MUL_DIGIT];
      acc_in    = (acc_ff << MUL_DIGIT) + PW'(pprod_in);
      mul_sh_in = acc_in >> FRAC_BITS;
      mul_m_in  = (|(mul_sh_in >> (W + 1))) ? {1'b1, {W{1'b0}}} : mul_sh_in[W:0];
      pn_neg_in = p_neg_ff ^ r_neg_ff;
      pn_mag_in = sat_mag(pn_neg_in, mul_m_in);
      pn_negf_in = pn_neg_in && (pn_mag_in != '0);

      // distance between radicand and power
      if (s_neg_ff == p_neg_ff) begin
         d_in = (s_mag_ff >= p_mag_ff) ? {1'b0, s_mag_ff - p_mag_ff}
                                       : {1'b0, p_mag_ff - s_mag_ff};
      end else begin
         d_in = {1'b0, s_mag_ff} + {1'b0, p_mag_ff};
      end

      // saturate the divider quotient two ways
      qm_in      = (|(div_quot >> (W + 1))) ? {1'b1, {W{1'b0}}} : div_quot[W:0];
      err_sat_in = (|(div_quot >> W)) ? {W{1'b1}} : div_quot[W-1:0];

      // divisor of the update: n * r^(n-1), saturated
      dprod_in   = pm1_mag_ff * n_ff;
      den_upd_in = (dprod_in > (W + ORDER_BITS)'(MAXMAG)) ? MAXMAG : dprod_in[W-1:0];

      t1m_in     = r_mag_ff - div_quot[W-1:0];

      // second term and signed sum
      t2_mag_in  = sat_mag(s_neg_ff ^ pm1_neg_ff, qm_in);
      t2_neg_in  = (s_neg_ff ^ pm1_neg_ff) && (t2_mag_in != '0);
      if (t1_neg_ff == t2_neg_in) begin
         rn_mag_in = sat_mag(t1_neg_ff, {1'b0, t1_mag_ff} + {1'b0, t2_mag_in});
         rn_neg_in = t1_neg_ff && (rn_mag_in != '0);
      end else if (t1_mag_ff >= t2_mag_in) begin
         rn_mag_in = t1_mag_ff - t2_mag_in;
         rn_neg_in = t1_neg_ff && (rn_mag_in != '0);
      end else begin
         rn_mag_in = t2_mag_in - t1_mag_ff;
         rn_neg_in = t2_neg_in;
      end

      // root that opens the power chain
      a_neg_in = (state_ff == S_INIT) ? (s_neg_ff && (div_quot[W-1:0] != '0)) : rn_neg_in;
      a_mag_in = (state_ff == S_INIT) ? div_quot[W-1:0] : rn_mag_in;

      // split the incoming radicand into sign and magnitude
      in_neg_in = req_radicand[W-1];
      in_mag_in = in_neg_in ? (~req_radicand + 1'b1) : req_radicand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= TOL_RESET;
         steps_max_ff <= STEPS_RESET;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_valid) begin
            if (csr_index == CSR_TOLERANCE) begin
               tol_ff <= csr_data;
            end else if (csr_index == CSR_MAX_STEPS) begin
               steps_max_ff <= csr_data[STEP_BITS-1:0];
            end
         end

         // drop the response once taken, unless a new one loads now
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  s_neg_ff <= in_neg_in;
                  s_mag_ff <= in_mag_in;
                  n_ff     <= req_order;
                  steps_ff <= '0;
                  r_neg_ff <= 1'b0;
                  r_mag_ff <= '0;
                  err_ff   <= '0;
                  if (req_order < ORDER_BITS'(2)) begin
                     status_ff    <= STATUS_BAD_ORDER;
                     div_start_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else if (!req_order[0] && in_neg_in) begin
                     status_ff    <= STATUS_NEG_EVEN;
                     div_start_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else if (in_mag_in == '0) begin
                     status_ff    <= STATUS_OK;
                     div_start_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else begin
                     div_num_ff   <= NW'(in_mag_in);
                     div_den_ff   <= W'(req_order);
                     div_start_ff <= 1'b1;
                     state_ff     <= S_INIT;
                  end
               end else begin
                  div_start_ff <= 1'b0;
               end
            end
            S_INIT, S_UPD2: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  // load new root and open the power chain
                  r_neg_ff   <= a_neg_in;
                  r_mag_ff   <= a_mag_in;
                  p_neg_ff   <= a_neg_in;
                  p_mag_ff   <= a_mag_in;
                  pm1_neg_ff <= a_neg_in;
                  pm1_mag_ff <= a_mag_in;
                  b_ff       <= BPW'(a_mag_in);
                  acc_ff     <= '0;
                  mcnt_ff    <= '0;
                  k_ff       <= ORDER_BITS'(2);
                  if (state_ff == S_UPD2) begin
                     steps_ff <= steps_ff + 1'b1;
                  end
                  state_ff   <= S_POW;
               end
            end
            S_POW: begin
               div_start_ff <= 1'b0;
               if (mcnt_ff == MCW'(NDIG - 1)) begin
                  p_neg_ff <= pn_negf_in;
                  p_mag_ff <= pn_mag_in;
                  acc_ff   <= '0;
                  b_ff     <= BPW'(r_mag_ff);
                  mcnt_ff  <= '0;
                  k_ff     <= k_ff + 1'b1;
                  if (k_ff == n_ff - 1'b1) begin
                     pm1_neg_ff <= pn_negf_in;
                     pm1_mag_ff <= pn_mag_in;
                  end
                  if (k_ff == n_ff) begin
                     state_ff <= S_ERRS;
                  end
               end else begin
                  acc_ff  <= acc_in;
                  b_ff    <= b_ff << MUL_DIGIT;
                  mcnt_ff <= mcnt_ff + 1'b1;
               end
            end
            S_ERRS: begin
               div_num_ff   <= NW'(d_in) << FRAC_BITS;
               div_den_ff   <= s_mag_ff;
               div_start_ff <= 1'b1;
               state_ff     <= S_ERR;
            end
            S_ERR: begin
               if (div_done) begin
                  err_ff <= err_sat_in;
                  if (CW'(err_sat_in) <= CW'(tol_ff)) begin
                     status_ff    <= STATUS_OK;
                     div_start_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else if (steps_ff >= steps_max_ff) begin
                     status_ff    <= STATUS_NO_CONV;
                     div_start_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else begin
                     div_num_ff   <= NW'(r_mag_ff);
                     div_den_ff   <= W'(n_ff);
                     div_start_ff <= 1'b1;
                     state_ff     <= S_UPD1;
                  end
               end else begin
                  div_start_ff <= 1'b0;
               end
            end
            S_UPD1: begin
               if (div_done) begin
                  t1_mag_ff    <= t1m_in;
                  t1_neg_ff    <= r_neg_ff && (t1m_in != '0);
                  div_num_ff   <= NW'(s_mag_ff) << FRAC_BITS;
                  div_den_ff   <= den_upd_in;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_UPD2;
               end else begin
                  div_start_ff <= 1'b0;
               end
            end
            S_DONE: begin
               div_start_ff <= 1'b0;
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_root_ff   <= r_neg_ff ? (~r_mag_ff + 1'b1) : r_mag_ff;
                  rsp_err_ff    <= err_ff;
                  rsp_status_ff <= status_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               div_start_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root      = rsp_root_ff;
   assign rsp_rel_error = rsp_err_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ----- src/nroot_div.sv -----
// ----------------------------------------------------------------------------
// nroot_div
// Restoring unsigned divider, one quotient bit per cycle. Full quotient is
// returned; the caller saturates it. A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
module nroot_div #(
   parameter int NUM_BITS = 49,
   parameter int DEN_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [DEN_BITS:0]   rem_sh_in;
   logic                take_in;
   logic [DEN_BITS:0]   rem_sub_in;

   // shift in the next numerator bit and trial subtract
   always_comb begin
      rem_sh_in  = {rem_ff, quot_ff[NUM_BITS-1]};
      take_in    = rem_sh_in >= {1'b0, den_ff};
      rem_sub_in = rem_sh_in - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            quot_ff <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= CNT_BITS'(NUM_BITS);
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end else if (busy_ff) begin
            rem_ff  <= take_in ? rem_sub_in[DEN_BITS-1:0] : rem_sh_in[DEN_BITS-1:0];
            quot_ff <= {quot_ff[NUM_BITS-2:0], take_in};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CNT_BITS'(1));
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
